>>> hdl/tun_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants of the triangle unit normal block
// Word formats, store geometry and datapath widths.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_BITS    = 24;
  localparam int INDEX_BITS    = 10;
  localparam int VERTEX_COUNT  = 1 << INDEX_BITS;
  localparam int FACE_COUNT    = 1 << INDEX_BITS;
  localparam int LIMIT_BITS    = 16;
  localparam int NORM_BITS     = 16;

  localparam int EDGE_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * EDGE_BITS;
  localparam int CROSS_BITS    = PROD_BITS + 1;
  localparam int A_BITS        = 31;
  localparam int SHIFT_BITS    = 5;
  localparam int SMALL_BITS    = 16;
  localparam int SUM_BITS      = 64;
  localparam int ROOT_BITS     = 32;
  localparam int QUOT_BITS     = NORM_BITS + 1;
  localparam int DIV_BITS      = A_BITS + NORM_BITS + 1;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_CNT_BITS = 3;

  localparam logic [LIMIT_BITS-1:0] MIN_LENGTH_RESET = 16'd17;

  typedef enum logic [1:0] {
    CMD_VERTEX = 2'd0,
    CMD_FACE   = 2'd1,
    CMD_NORMAL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                          command;
    logic [INDEX_BITS-1:0]         index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;
    logic [INDEX_BITS-1:0]         corner_a;
    logic [INDEX_BITS-1:0]         corner_b;
    logic [INDEX_BITS-1:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic                        degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] a;
    logic [INDEX_BITS-1:0] b;
    logic [INDEX_BITS-1:0] c;
  } face_t;

  typedef struct packed {
    vertex_t v0;
    vertex_t v1;
    vertex_t v2;
  } tri_t;

endpackage

>>> hdl/triangle_unit_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal from stored vertices
// Vertex and face stores, corner fetch, cross product and Q1.15 normalize.
//
//   channel   direction  handshake                 word
//   in        input      in_valid_i / in_ready_o   in_item_t
//   out       output     out_valid_o / out_ready_i out_item_t
//   cfg       input      cfg_we_i                  min_length (16 bits)
//
// One word per cycle in and out while neither side stalls; each normal passes
// through the 32-stage square root and 17-stage divider pipes.
// Reset clears control and sets min_length to 17; store contents are not
// cleared. The back pipe holds while the output word waits; the front keeps
// taking words until the four-entry triangle queue is spoken for.
// ----------------------------------------------------------------------------
module triangle_unit_normal (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tun_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tun_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tun_pkg::LIMIT_BITS-1:0]  cfg_data_i
);
  import tun_pkg::*;

  logic [LIMIT_BITS-1:0]    min_length_q;
  logic [FIFO_CNT_BITS-1:0] fifo_count;
  logic                     push, pop, pop_valid;
  tri_t                     push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= MIN_LENGTH_RESET;
    end else if (cfg_we_i) begin
      min_length_q <= cfg_data_i;
    end
  end

  tun_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  tun_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .count_o     (fifo_count)
  );

  tun_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tri_valid_i  (pop_valid),
    .tri_data_i   (pop_data),
    .tri_pop_o    (pop),
    .min_length_i (min_length_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> hdl/tun_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_fifo: triangle queue between front and back
// Short queue of fetched vertex triples; reports its fill level.
// ----------------------------------------------------------------------------
module tun_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  tun_pkg::tri_t                 push_data_i,
  input  logic                          pop_i,
  output logic                          pop_valid_o,
  output tun_pkg::tri_t                 pop_data_o,
  output logic [tun_pkg::FIFO_CNT_BITS-1:0] count_o
);
  import tun_pkg::*;

  tri_t                     mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + FIFO_PTR_BITS'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + FIFO_PTR_BITS'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CNT_BITS'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - FIFO_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_data_i;
    end
  end

  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem[rd_q];
  assign count_o     = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

>>> hdl/tun_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_front: command intake and store access
// Takes input words, fills the vertex and face stores, fetches the three
// corners of each normal request and hands the triple to the queue.
// ----------------------------------------------------------------------------
module tun_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tun_pkg::in_item_t                 in_data_i,
  input  logic [tun_pkg::FIFO_CNT_BITS-1:0] fifo_count_i,
  output logic                              push_o,
  output tun_pkg::tri_t                     push_data_o
);
  import tun_pkg::*;

  face_t   face_mem [FACE_COUNT];
  vertex_t vtx_mem0 [VERTEX_COUNT];
  vertex_t vtx_mem1 [VERTEX_COUNT];
  vertex_t vtx_mem2 [VERTEX_COUNT];

  logic    accept;
  logic    f1_valid_q, f2_valid_q;
  face_t   face_q;
  vertex_t v0_q, v1_q, v2_q;
  vertex_t wr_vtx;
  logic [FIFO_CNT_BITS:0] outstanding;

  assign outstanding = {1'b0, fifo_count_i} + (FIFO_CNT_BITS + 1)'(f1_valid_q)
                     + (FIFO_CNT_BITS + 1)'(f2_valid_q);
  assign in_ready_o  = outstanding < (FIFO_CNT_BITS + 1)'(FIFO_DEPTH);
  assign accept      = in_valid_i && in_ready_o;

  assign wr_vtx = '{x: in_data_i.coord_x, y: in_data_i.coord_y, z: in_data_i.coord_z};

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.command == CMD_FACE) begin
      face_mem[in_data_i.index] <= '{a: in_data_i.corner_a, b: in_data_i.corner_b,
                                     c: in_data_i.corner_c};
    end
    if (accept) begin
      face_q <= face_mem[in_data_i.index];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.command == CMD_VERTEX) begin
      vtx_mem0[in_data_i.index] <= wr_vtx;
      vtx_mem1[in_data_i.index] <= wr_vtx;
      vtx_mem2[in_data_i.index] <= wr_vtx;
    end
    v0_q <= vtx_mem0[face_q.a];
    v1_q <= vtx_mem1[face_q.b];
    v2_q <= vtx_mem2[face_q.c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept && in_data_i.command == CMD_NORMAL;
      f2_valid_q <= f1_valid_q;
    end
  end

  assign push_o      = f2_valid_q;
  assign push_data_o = '{v0: v0_q, v1: v1_q, v2: v2_q};

endmodule

>>> hdl/tun_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_back: normal arithmetic pipeline
// Edges, cross product, degeneracy test, pipelined square root and three
// pipelined dividers; the whole pipe advances unless an output word waits.
// ----------------------------------------------------------------------------
module tun_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             tri_valid_i,
  input  tun_pkg::tri_t                    tri_data_i,
  output logic                             tri_pop_o,
  input  logic [tun_pkg::LIMIT_BITS-1:0]   min_length_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tun_pkg::out_item_t               out_data_o
);
  import tun_pkg::*;

  localparam int SQRT_STAGES = ROOT_BITS;
  localparam int LAT         = 7 + SQRT_STAGES + 1 + QUOT_BITS + 1;
  localparam int TRIAL_BITS  = SUM_BITS + 2;
  localparam int SUBW        = DIV_BITS + 2;

  logic           adv;
  logic [LAT-1:0] vld_q;

  // stage 1..3: edges, products, cross product magnitude
  logic signed [EDGE_BITS-1:0]  e1_q [3];
  logic signed [EDGE_BITS-1:0]  e2_q [3];
  logic signed [PROD_BITS-1:0]  p_q  [6];
  logic signed [CROSS_BITS-1:0] n    [3];
  logic [CROSS_BITS-1:0]        mag_q [3];
  logic [2:0]                   neg3_q, neg4_q, neg5_q, neg6_q;

  // stage 4..7: degeneracy test, scaling, squares
  logic [CROSS_BITS-1:0]        all_mag;
  logic [SHIFT_BITS-1:0]        shift;
  logic [CROSS_BITS-1:0]        mag4_q [3];
  logic [2*SMALL_BITS-1:0]      sq16_q [3];
  logic [2*SMALL_BITS+1:0]      lim_q;
  logic [LIMIT_BITS:0]          lim_base;
  logic                         small_q;
  logic [SHIFT_BITS-1:0]        shift_q;
  logic [2*SMALL_BITS+1:0]      sum16;
  logic                         degen5_q, degen6_q;
  logic [2:0][A_BITS-1:0]       a5_q, a6_q;
  logic [2*A_BITS-1:0]          asq_q [3];

  // square root pipe
  logic [SUM_BITS-1:0]          sq_rem_q  [SQRT_STAGES+1];
  logic [ROOT_BITS-1:0]         sq_root_q [SQRT_STAGES+1];
  logic [2:0][A_BITS-1:0]       sq_a_q    [SQRT_STAGES+1];
  logic [2:0]                   sq_neg_q  [SQRT_STAGES+1];
  logic                         sq_deg_q  [SQRT_STAGES+1];
  logic [TRIAL_BITS-1:0]        sq_trial  [SQRT_STAGES];
  logic                         sq_ge     [SQRT_STAGES];

  // divider pipe
  logic [2:0][DIV_BITS-1:0]     dv_rem_q [QUOT_BITS+1];
  logic [2:0][QUOT_BITS-1:0]    dv_quo_q [QUOT_BITS+1];
  logic [ROOT_BITS:0]           dv_den_q [QUOT_BITS+1];
  logic [2:0]                   dv_neg_q [QUOT_BITS+1];
  logic                         dv_deg_q [QUOT_BITS+1];
  logic [SUBW-1:0]              dv_sub   [QUOT_BITS];

  out_item_t                    out_q;
  logic [NORM_BITS-1:0]         comp [3];
  logic [QUOT_BITS-1:0]         quo;

  assign adv       = !vld_q[LAT-1] || out_ready_i;
  assign tri_pop_o = adv && tri_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], tri_valid_i};
    end
  end

  // cross product
  always_comb begin
    n[0] = CROSS_BITS'(p_q[0]) - CROSS_BITS'(p_q[1]);
    n[1] = CROSS_BITS'(p_q[2]) - CROSS_BITS'(p_q[3]);
    n[2] = CROSS_BITS'(p_q[4]) - CROSS_BITS'(p_q[5]);
  end

  always_comb begin
    all_mag = mag_q[0] | mag_q[1] | mag_q[2];
    shift   = '0;
    for (int i = 0; i < CROSS_BITS - A_BITS; i++) begin
      if (all_mag[A_BITS+i]) begin
        shift = SHIFT_BITS'(i + 1);
      end
    end
    lim_base = {1'b0, min_length_i} + (LIMIT_BITS + 1)'(1);
    sum16 = (2*SMALL_BITS+2)'(sq16_q[0]) + (2*SMALL_BITS+2)'(sq16_q[1])
          + (2*SMALL_BITS+2)'(sq16_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q[0] <= EDGE_BITS'(tri_data_i.v1.x) - EDGE_BITS'(tri_data_i.v0.x);
      e1_q[1] <= EDGE_BITS'(tri_data_i.v1.y) - EDGE_BITS'(tri_data_i.v0.y);
      e1_q[2] <= EDGE_BITS'(tri_data_i.v1.z) - EDGE_BITS'(tri_data_i.v0.z);
      e2_q[0] <= EDGE_BITS'(tri_data_i.v2.x) - EDGE_BITS'(tri_data_i.v0.x);
      e2_q[1] <= EDGE_BITS'(tri_data_i.v2.y) - EDGE_BITS'(tri_data_i.v0.y);
      e2_q[2] <= EDGE_BITS'(tri_data_i.v2.z) - EDGE_BITS'(tri_data_i.v0.z);

      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];

      for (int i = 0; i < 3; i++) begin
        neg3_q[i] <= n[i][CROSS_BITS-1];
        mag_q[i]  <= n[i][CROSS_BITS-1] ? CROSS_BITS'(-n[i]) : CROSS_BITS'(n[i]);
      end

      for (int i = 0; i < 3; i++) begin
        mag4_q[i] <= mag_q[i];
        sq16_q[i] <= mag_q[i][SMALL_BITS-1:0] * mag_q[i][SMALL_BITS-1:0];
      end
      neg4_q  <= neg3_q;
      small_q <= all_mag[CROSS_BITS-1:SMALL_BITS] == '0;
      lim_q   <= lim_base * lim_base;
      shift_q <= shift;

      for (int i = 0; i < 3; i++) begin
        a5_q[i] <= A_BITS'(mag4_q[i] >> shift_q);
      end
      neg5_q   <= neg4_q;
      degen5_q <= small_q && (sum16 < lim_q);

      for (int i = 0; i < 3; i++) begin
        asq_q[i] <= a5_q[i] * a5_q[i];
      end
      a6_q     <= a5_q;
      neg6_q   <= neg5_q;
      degen6_q <= degen5_q;

      sq_rem_q[0]  <= SUM_BITS'(asq_q[0]) + SUM_BITS'(asq_q[1]) + SUM_BITS'(asq_q[2]);
      sq_root_q[0] <= '0;
      sq_a_q[0]    <= a6_q;
      sq_neg_q[0]  <= neg6_q;
      sq_deg_q[0]  <= degen6_q;
    end
  end

  // square root, one root bit per stage
  always_comb begin
    for (int j = 0; j < SQRT_STAGES; j++) begin
      sq_trial[j] = (TRIAL_BITS'(sq_root_q[j]) << (ROOT_BITS - j))
                  | (TRIAL_BITS'(1) << (2 * (ROOT_BITS - 1 - j)));
      sq_ge[j]    = {2'b00, sq_rem_q[j]} >= sq_trial[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < SQRT_STAGES; j++) begin
        sq_rem_q[j+1]  <= sq_ge[j] ? sq_rem_q[j] - sq_trial[j][SUM_BITS-1:0] : sq_rem_q[j];
        sq_root_q[j+1] <= sq_ge[j] ? sq_root_q[j] | (ROOT_BITS'(1) << (ROOT_BITS - 1 - j))
                                   : sq_root_q[j];
        sq_a_q[j+1]    <= sq_a_q[j];
        sq_neg_q[j+1]  <= sq_neg_q[j];
        sq_deg_q[j+1]  <= sq_deg_q[j];
      end
    end
  end

  // rounded quotient a * 2^15 / len, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < QUOT_BITS; j++) begin
      dv_sub[j] = SUBW'(dv_den_q[j]) << (QUOT_BITS - 1 - j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= DIV_BITS'({sq_a_q[SQRT_STAGES][i], NORM_BITS'(0)})
                        + DIV_BITS'(sq_root_q[SQRT_STAGES]);
        dv_quo_q[0][i] <= '0;
      end
      dv_den_q[0] <= {sq_root_q[SQRT_STAGES], 1'b0};
      dv_neg_q[0] <= sq_neg_q[SQRT_STAGES];
      dv_deg_q[0] <= sq_deg_q[SQRT_STAGES];

      for (int j = 0; j < QUOT_BITS; j++) begin
        for (int i = 0; i < 3; i++) begin
          if ({2'b00, dv_rem_q[j][i]} >= dv_sub[j]) begin
            dv_rem_q[j+1][i] <= dv_rem_q[j][i] - dv_sub[j][DIV_BITS-1:0];
            dv_quo_q[j+1][i] <= dv_quo_q[j][i] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - j));
          end else begin
            dv_rem_q[j+1][i] <= dv_rem_q[j][i];
            dv_quo_q[j+1][i] <= dv_quo_q[j][i];
          end
        end
        dv_den_q[j+1] <= dv_den_q[j];
        dv_neg_q[j+1] <= dv_neg_q[j];
        dv_deg_q[j+1] <= dv_deg_q[j];
      end

      out_q <= '{normal_x: comp[0], normal_y: comp[1], normal_z: comp[2],
                 degenerate: dv_deg_q[QUOT_BITS]};
    end
  end

  // sign, saturation and degenerate zeroing
  always_comb begin
    quo = '0;
    for (int i = 0; i < 3; i++) begin
      quo = dv_quo_q[QUOT_BITS][i];
      if (dv_deg_q[QUOT_BITS]) begin
        comp[i] = '0;
      end else if (dv_neg_q[QUOT_BITS][i]) begin
        comp[i] = NORM_BITS'(-quo);
      end else if (quo[QUOT_BITS-1:NORM_BITS-1] != '0) begin
        comp[i] = {1'b0, {(NORM_BITS-1){1'b1}}};
      end else begin
        comp[i] = quo[NORM_BITS-1:0];
      end
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_data_o  = out_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 && out_data_o.normal_z == '0)
    else $error("degenerate word with nonzero normal");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-2] && !dv_deg_q[QUOT_BITS] |->
      dv_quo_q[QUOT_BITS][0] <= QUOT_BITS'(1 << NORM_BITS - 1)
      && dv_quo_q[QUOT_BITS][1] <= QUOT_BITS'(1 << NORM_BITS - 1)
      && dv_quo_q[QUOT_BITS][2] <= QUOT_BITS'(1 << NORM_BITS - 1))
    else $error("normal quotient above unity");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q) && $stable(out_q))
    else $error("pipe moved during output stall");

  a_pop_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_pop_o |=> vld_q[0])
    else $error("popped triangle not captured");

endmodule
